// ----- src/llcf_pkg.sv -----
// Shared constants, register indexes and controller/datapath word types
// for the liquid level calibration filter. No dependencies.
package llcf_pkg;

    // Moving-average window depth.
    localparam int WINDOW_SIZE = 5;

    // Level width: mm in unsigned Q4.
    localparam int LVL_W   = 20;
    localparam int IDX_W   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W   = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W   = LVL_W + $clog2(WINDOW_SIZE);

    // Calibration dividend is a 20-bit sum scaled by 16.
    localparam int CAL_DVD_W = 24;
    localparam int DVD_W     = (SUM_W > CAL_DVD_W) ? SUM_W : CAL_DVD_W;
    localparam int DVS_W     = (CNT_W > 4) ? CNT_W : 4;
    localparam int DCNT_W    = $clog2(DVD_W);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HIGH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_SAMPLES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_GROUND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MAX      = 3'd4;

    localparam logic [15:0] RST_ALARM_HIGH     = 16'd200;
    localparam logic [3:0]  RST_CALIB_SAMPLES  = 4'd10;
    localparam logic [7:0]  RST_CALIB_TIMEOUT  = 8'd40;
    localparam logic [15:0] RST_DEFAULT_GROUND = 16'd500;
    localparam logic [15:0] RST_LEVEL_MAX      = 16'd5000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic cal_update;
        logic div_start;
        logic div_sel_win;
        logic ground_from_div;
        logic ground_default;
        logic cal_finish;
        logic push;
        logic sum_step;
        logic level_from_div;
        logic out_load;
    } llcf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic calib_finished;
        logic fine_valid;
        logic samples_reached;
        logic timed_out;
        logic raw_ok;
        logic sum_last;
        logic div_done;
    } llcf_sts_t;

endpackage

// ----- src/llcf_if.sv -----
// Channel interfaces: measurement input, result output and register write.
// Depends on llcf_pkg for the configuration port widths.
interface llcf_meas_if;
    logic        valid;
    logic        ready;
    logic        coarse_valid;
    logic [15:0] coarse_mm;
    logic        fine_valid;
    logic [15:0] fine_mm;

    modport source (output valid, output coarse_valid, output coarse_mm,
                    output fine_valid, output fine_mm, input ready);
    modport sink   (input valid, input coarse_valid, input coarse_mm,
                    input fine_valid, input fine_mm, output ready);
endinterface

interface llcf_res_if;
    logic               valid;
    logic               ready;
    logic               calibrated;
    logic [19:0]        level_q4;
    logic signed [21:0] delta_q4;
    logic [15:0]        liquid_distance_mm;
    logic               alarm_high_on;

    modport source (output valid, output calibrated, output level_q4,
                    output delta_q4, output liquid_distance_mm,
                    output alarm_high_on, input ready);
    modport sink   (input valid, input calibrated, input level_q4,
                    input delta_q4, input liquid_distance_mm,
                    input alarm_high_on, output ready);
endinterface

interface llcf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [llcf_pkg::CFG_IDX_W-1:0]  index;
    logic [llcf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/llcf_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on llcf_pkg for dividend and divisor widths.
module llcf_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [llcf_pkg::DVD_W-1:0]  dividend,
    input  logic [llcf_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [llcf_pkg::DVD_W-1:0]  quotient
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [llcf_pkg::DCNT_W-1:0]  step_reg;
    logic [llcf_pkg::DVD_W-1:0]   quo_reg;
    logic [llcf_pkg::DVS_W-1:0]   rem_reg;
    logic [llcf_pkg::DVS_W-1:0]   dvs_reg;

    logic [llcf_pkg::DVS_W:0]     rem_shift;
    logic [llcf_pkg::DVS_W:0]     rem_diff;
    logic                         fits;
    logic [llcf_pkg::DVS_W-1:0]   rem_next;
    logic [llcf_pkg::DVD_W-1:0]   quo_next;
    logic                         last_step;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[llcf_pkg::DVD_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});
        rem_next  = fits ? rem_diff[llcf_pkg::DVS_W-1:0] : rem_shift[llcf_pkg::DVS_W-1:0];
        quo_next  = {quo_reg[llcf_pkg::DVD_W-2:0], fits};
        last_step = (step_reg == llcf_pkg::DCNT_W'(llcf_pkg::DVD_W - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + llcf_pkg::DCNT_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/llcf_dp.sv -----
// Datapath: registers, calibration accumulator, window store and shared divider.
// Depends on llcf_pkg and llcf_div; driven by llcf_ctrl commands.
module llcf_dp
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  llcf_pkg::llcf_cmd_t               cmd,
    output llcf_pkg::llcf_sts_t               sts,
    input  logic                              meas_coarse_valid,
    input  logic [15:0]                       meas_coarse_mm,
    input  logic                              meas_fine_valid,
    input  logic [15:0]                       meas_fine_mm,
    input  logic                              cfg_we,
    input  logic [llcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [llcf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              res_calibrated,
    output logic [19:0]                       res_level_q4,
    output logic signed [21:0]                res_delta_q4,
    output logic [15:0]                       res_liquid_distance_mm,
    output logic                              res_alarm_high_on
);

    // Configuration registers
    logic [15:0] alarm_high_reg;
    logic [3:0]  calib_samples_reg;
    logic [7:0]  calib_timeout_reg;
    logic [15:0] default_ground_reg;
    logic [15:0] level_max_reg;

    // Latched measurement
    logic        coarse_valid_reg;
    logic [15:0] coarse_mm_reg;
    logic        fine_valid_reg;
    logic [15:0] fine_mm_reg;

    // Calibration and level state
    logic        calib_finished_reg;
    logic [3:0]  sample_count_reg;
    logic [7:0]  step_count_reg;
    logic [19:0] calib_sum_reg;
    logic [19:0] ground_reg;
    logic [20:0] initial_reg;
    logic [19:0] level_reg;
    logic [21:0] delta_reg;
    logic [15:0] last_dist_reg;

    // Window
    logic [llcf_pkg::LVL_W-1:0] window_reg [llcf_pkg::WINDOW_SIZE];
    logic [llcf_pkg::IDX_W-1:0] wr_idx_reg;
    logic                       filled_reg;
    logic [llcf_pkg::CNT_W-1:0] cnt_reg;
    logic [llcf_pkg::IDX_W-1:0] sum_i_reg;
    logic [llcf_pkg::SUM_W-1:0] acc_reg;

    // Output word
    logic        out_calibrated_reg;
    logic [19:0] out_level_reg;
    logic [21:0] out_delta_reg;
    logic [15:0] out_dist_reg;
    logic        out_alarm_reg;

    logic [3:0]                 need;
    logic [20:0]                raw;
    logic [20:0]                calib_sum_wide;
    logic [19:0]                calib_sum_next;
    logic                       coarse_take;
    logic                       window_last;
    logic [llcf_pkg::CNT_W-1:0] cnt_next;
    logic [21:0]                delta_next;
    logic                       alarm_next;
    logic [llcf_pkg::DVD_W-1:0] div_dvd;
    logic [llcf_pkg::DVS_W-1:0] div_dvs;
    logic                       div_done;
    logic [llcf_pkg::DVD_W-1:0] div_quo;

    always_comb
    begin
        need           = (calib_samples_reg == 4'd0) ? 4'd1 : calib_samples_reg;
        raw            = {1'b0, ground_reg} - {1'b0, fine_mm_reg, 4'b0000};
        coarse_take    = coarse_valid_reg && (coarse_mm_reg != 16'd0);
        calib_sum_wide = {1'b0, calib_sum_reg} + {5'd0, coarse_mm_reg};
        calib_sum_next = calib_sum_wide[19:0];
        window_last    = (wr_idx_reg == llcf_pkg::IDX_W'(llcf_pkg::WINDOW_SIZE - 1));
        cnt_next       = (filled_reg || window_last) ? llcf_pkg::CNT_W'(llcf_pkg::WINDOW_SIZE)
                                                     : llcf_pkg::CNT_W'(wr_idx_reg)
                                                       + llcf_pkg::CNT_W'(1);
        delta_next     = {2'b00, div_quo[llcf_pkg::LVL_W-1:0]}
                         - {initial_reg[20], initial_reg};
        alarm_next     = calib_finished_reg && (alarm_high_reg != 16'd0)
                         && (level_reg >= {alarm_high_reg, 4'b0000});
        div_dvd        = cmd.div_sel_win ? llcf_pkg::DVD_W'(acc_reg)
                                         : llcf_pkg::DVD_W'({calib_sum_reg, 4'b0000});
        div_dvs        = cmd.div_sel_win ? llcf_pkg::DVS_W'(cnt_reg)
                                         : llcf_pkg::DVS_W'(need);
    end

    llcf_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        sts.calib_finished  = calib_finished_reg;
        sts.fine_valid      = fine_valid_reg;
        sts.samples_reached = (sample_count_reg >= need);
        sts.timed_out       = (step_count_reg >= calib_timeout_reg);
        sts.raw_ok          = !raw[20] && (raw[19:0] <= {level_max_reg, 4'b0000});
        sts.sum_last        = (llcf_pkg::CNT_W'(sum_i_reg) == cnt_reg - llcf_pkg::CNT_W'(1));
        sts.div_done        = div_done;
    end

    // Configuration and state with defined reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_high_reg     <= llcf_pkg::RST_ALARM_HIGH;
            calib_samples_reg  <= llcf_pkg::RST_CALIB_SAMPLES;
            calib_timeout_reg  <= llcf_pkg::RST_CALIB_TIMEOUT;
            default_ground_reg <= llcf_pkg::RST_DEFAULT_GROUND;
            level_max_reg      <= llcf_pkg::RST_LEVEL_MAX;
            calib_finished_reg <= 1'b0;
            sample_count_reg   <= '0;
            step_count_reg     <= '0;
            calib_sum_reg      <= '0;
            ground_reg         <= '0;
            initial_reg        <= '0;
            level_reg          <= '0;
            delta_reg          <= '0;
            last_dist_reg      <= '0;
            wr_idx_reg         <= '0;
            filled_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    llcf_pkg::CFG_ALARM_HIGH:     alarm_high_reg     <= cfg_data;
                    llcf_pkg::CFG_CALIB_SAMPLES:  calib_samples_reg  <= cfg_data[3:0];
                    llcf_pkg::CFG_CALIB_TIMEOUT:  calib_timeout_reg  <= cfg_data[7:0];
                    llcf_pkg::CFG_DEFAULT_GROUND: default_ground_reg <= cfg_data;
                    llcf_pkg::CFG_LEVEL_MAX:      level_max_reg      <= cfg_data;
                    default:                      ;
                endcase
            end

            if (cmd.cal_update)
            begin
                if (step_count_reg != 8'hFF)
                    step_count_reg <= step_count_reg + 8'd1;
                if (coarse_take)
                begin
                    calib_sum_reg <= calib_sum_next;
                    if (sample_count_reg != 4'hF)
                        sample_count_reg <= sample_count_reg + 4'd1;
                end
            end

            if (cmd.ground_from_div)
                ground_reg <= div_quo[19:0];
            else if (cmd.ground_default)
                ground_reg <= {default_ground_reg, 4'b0000};

            if (cmd.cal_finish)
            begin
                calib_finished_reg <= 1'b1;
                if (fine_valid_reg)
                begin
                    last_dist_reg <= fine_mm_reg;
                    initial_reg   <= raw;
                    level_reg     <= raw[20] ? 20'd0 : raw[19:0];
                    delta_reg     <= '0;
                end
            end

            if (cmd.push)
            begin
                last_dist_reg <= fine_mm_reg;
                if (window_last)
                begin
                    wr_idx_reg <= '0;
                    filled_reg <= 1'b1;
                end
                else
                    wr_idx_reg <= wr_idx_reg + llcf_pkg::IDX_W'(1);
            end

            if (cmd.level_from_div)
            begin
                level_reg <= div_quo[llcf_pkg::LVL_W-1:0];
                delta_reg <= delta_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            coarse_valid_reg <= meas_coarse_valid;
            coarse_mm_reg    <= meas_coarse_mm;
            fine_valid_reg   <= meas_fine_valid;
            fine_mm_reg      <= meas_fine_mm;
        end

        if (cmd.push)
        begin
            window_reg[wr_idx_reg] <= raw[19:0];
            cnt_reg                <= cnt_next;
            sum_i_reg              <= '0;
            acc_reg                <= '0;
        end
        else if (cmd.sum_step)
        begin
            acc_reg   <= acc_reg + llcf_pkg::SUM_W'(window_reg[sum_i_reg]);
            sum_i_reg <= sum_i_reg + llcf_pkg::IDX_W'(1);
        end

        if (cmd.out_load)
        begin
            out_calibrated_reg <= calib_finished_reg;
            out_level_reg      <= level_reg;
            out_delta_reg      <= delta_reg;
            out_dist_reg       <= last_dist_reg;
            out_alarm_reg      <= alarm_next;
        end
    end

    assign res_calibrated         = out_calibrated_reg;
    assign res_level_q4           = out_level_reg;
    assign res_delta_q4           = $signed(out_delta_reg);
    assign res_liquid_distance_mm = out_dist_reg;
    assign res_alarm_high_on      = out_alarm_reg;

`ifndef SYNTH
    a_wr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_idx_reg <= llcf_pkg::IDX_W'(llcf_pkg::WINDOW_SIZE - 1))
        else $error("window write index beyond window");

    a_sum_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_step |-> (llcf_pkg::CNT_W'(sum_i_reg) < cnt_reg))
        else $error("window sum reads past the filled entries");

    a_calib_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        calib_finished_reg |=> calib_finished_reg)
        else $error("calibration flag dropped");

    a_level_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.level_from_div |-> (div_quo[llcf_pkg::DVD_W-1:llcf_pkg::LVL_W] == '0))
        else $error("window mean overflows the level width");
`endif

endmodule

// ----- src/llcf_ctrl.sv -----
// Controller: sequences one measurement word through calibration or filtering.
// Depends on llcf_pkg; drives llcf_dp through command and status words.
module llcf_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 meas_valid,
    output logic                 meas_ready,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  llcf_pkg::llcf_sts_t  sts,
    output llcf_pkg::llcf_cmd_t  cmd
);

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_CAL,
        ST_CEVAL,
        ST_CDIV,
        ST_CFIN,
        ST_CHK,
        ST_SUM,
        ST_WSTART,
        ST_WDIV,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (meas_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.calib_finished ? ST_CHK : ST_CAL;
                end
            end
            ST_CAL:
            begin
                cmd.cal_update = 1'b1;
                state_next     = ST_CEVAL;
            end
            ST_CEVAL:
            begin
                if (sts.samples_reached)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_CDIV;
                end
                else if (sts.timed_out)
                begin
                    cmd.ground_default = 1'b1;
                    state_next         = ST_CFIN;
                end
                else
                    state_next = ST_DONE;
            end
            ST_CDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.ground_from_div = 1'b1;
                    state_next          = ST_CFIN;
                end
            end
            ST_CFIN:
            begin
                cmd.cal_finish = 1'b1;
                state_next     = ST_DONE;
            end
            ST_CHK:
            begin
                if (sts.fine_valid && sts.raw_ok)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_SUM;
                end
                else
                    state_next = ST_DONE;
            end
            ST_SUM:
            begin
                cmd.sum_step = 1'b1;
                if (sts.sum_last)
                    state_next = ST_WSTART;
            end
            ST_WSTART:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_win = 1'b1;
                state_next      = ST_WDIV;
            end
            ST_WDIV:
            begin
                if (sts.div_done)
                begin
                    cmd.level_from_div = 1'b1;
                    state_next         = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign meas_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

`ifndef SYNTH
    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == ST_CDIV || state_reg == ST_WDIV))
        else $error("divider finished with nobody waiting");

    a_push_calibrated: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> sts.calib_finished)
        else $error("window push before calibration");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !result_ready) |=> (state_reg == ST_DONE))
        else $error("pending result overwritten");
`endif

endmodule

// ----- src/liquid_level_calib_filter.sv -----
// Top level of the liquid level calibration filter.
// Depends on llcf_pkg, llcf_if, llcf_ctrl, llcf_dp and llcf_div.

// One measurement word in gives one result word out. Until calibration ends,
// nonzero valid coarse distances are summed; once calib_samples of them are in,
// the ground distance is their mean, or default_ground_mm once calib_timeout
// steps have gone by, and a valid fine reading in that step sets the initial
// level. Afterwards each valid fine reading gives ground minus distance; a value
// in 0..level_max_mm (Q4) goes through a 5-entry moving average, anything else
// leaves every output as it was. Levels are mm in unsigned Q4, truncated.
// A word is taken only while the block is idle. A calibration step that
// finishes on the sample count waits on the shared 24-step restoring divider
// for the mean. A calibrated accepted reading first runs through the serial
// window sum over the filled window entries (up to 5), then through the same
// divider. The result sits in an output register so the next word can be
// taken while it waits. No clearing pass after reset: only written window
// entries are ever summed. Register writes are taken every cycle.
module liquid_level_calib_filter
(
    input  logic        clk,
    input  logic        rst_n,
    llcf_meas_if.sink   meas,
    llcf_res_if.source  result,
    llcf_cfg_if.sink    cfg
);

    llcf_pkg::llcf_cmd_t cmd;
    llcf_pkg::llcf_sts_t sts;

    // Register writes never stall.
    assign cfg.ready = 1'b1;

    // Sequence each word; hold the result until taken.
    llcf_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .meas_valid   (meas.valid),
        .meas_ready   (meas.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    // Calibration, window filter, divider and output register.
    llcf_dp u_dp
    (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .cmd                    (cmd),
        .sts                    (sts),
        .meas_coarse_valid      (meas.coarse_valid),
        .meas_coarse_mm         (meas.coarse_mm),
        .meas_fine_valid        (meas.fine_valid),
        .meas_fine_mm           (meas.fine_mm),
        .cfg_we                 (cfg.valid),
        .cfg_index              (cfg.index),
        .cfg_data               (cfg.data),
        .res_calibrated         (result.calibrated),
        .res_level_q4           (result.level_q4),
        .res_delta_q4           (result.delta_q4),
        .res_liquid_distance_mm (result.liquid_distance_mm),
        .res_alarm_high_on      (result.alarm_high_on)
    );

endmodule
